// File: sv/cslx_pkg.sv
package cslx_pkg;

  localparam int KW_ENTRIES = 64;
  localparam int KW_BYTES   = 32;
  localparam int WORD_KEEP  = 30;
  localparam int RUN_BITS   = 24;
  localparam int QDEPTH     = 4;

  localparam int E_W    = $clog2(KW_ENTRIES);
  localparam int K_W    = $clog2(KW_BYTES);
  localparam int KW_AW  = E_W + K_W;
  localparam int WLEN_W = $clog2(WORD_KEEP + 1);
  localparam int Q_AW   = $clog2(QDEPTH);

  localparam logic [3:0] ST_DEFAULT = 4'd0;
  localparam logic [3:0] ST_COMMENT = 4'd1;
  localparam logic [3:0] ST_LINE    = 4'd2;
  localparam logic [3:0] ST_NUMBER  = 4'd4;
  localparam logic [3:0] ST_WORD    = 4'd5;
  localparam logic [3:0] ST_STRING  = 4'd6;
  localparam logic [3:0] ST_CHAR    = 4'd7;
  localparam logic [3:0] ST_PRE     = 4'd9;

  // One entry of the queue between the lexer and the style/output side.
  typedef struct packed {
    logic                           is_write;
    logic [KW_AW-1:0]               waddr;
    logic [7:0]                     wdata;
    logic [3:0]                     style;
    logic                           need_match;
    logic [RUN_BITS-1:0]            len;
    logic                           final_run;
    logic [WLEN_W-1:0]              wlen;
    logic [WORD_KEEP-1:0][7:0]      word;
  } rec_t;

endpackage

// File: sv/cslx_in_if.sv
interface cslx_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic [5:0] keyword_slot;
  logic [4:0] keyword_pos;
  logic       end_of_doc;

  modport source (output valid, mode, data_byte, keyword_slot, keyword_pos, end_of_doc,
                  input ready);
  modport sink (input valid, mode, data_byte, keyword_slot, keyword_pos, end_of_doc,
                output ready);
endinterface

// File: sv/cslx_out_if.sv
interface cslx_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  style;
  logic [23:0] run_length;
  logic        final_run;

  modport source (output valid, style, run_length, final_run, input ready);
  modport sink (input valid, style, run_length, final_run, output ready);
endinterface

// File: sv/cslx_front.sv
module cslx_front (
  input  logic                clk,
  input  logic                rst_n,
  cslx_in_if.sink             in_word,
  input  logic                clearing,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  output cslx_pkg::rec_t      q_din,
  output logic                q_push,
  input  logic                q_full
);
  import cslx_pkg::*;

  typedef enum logic [1:0] {
    HOLD_SLASH_OPEN  = 2'd0,
    HOLD_SLASH_AFTER = 2'd1,
    HOLD_ESCAPE      = 2'd2
  } hold_t;

  typedef struct packed {
    logic [3:0]                ls;
    logic                      hv;
    hold_t                     hk;
    logic [7:0]                pb;
    logic [1:0]                sk;
    logic [RUN_BITS-1:0]       rc;
    logic                      ao;
    logic [WLEN_W-1:0]         wl;
    logic [WORD_KEEP-1:0][7:0] wb;
    logic [1:0]                n;
    rec_t [1:0]                recs;
  } lx_t;

  logic [3:0]                lex_r, init_r;
  logic                      hv_r, ao_r, dopen_r;
  hold_t                     hk_r;
  logic [7:0]                prev_r;
  logic [1:0]                skip_r;
  logic [RUN_BITS-1:0]       rc_r;
  logic [WLEN_W-1:0]         wl_r;
  logic [WORD_KEEP-1:0][7:0] wb_r;
  rec_t [1:0]                pend_r;
  logic [1:0]                pend_cnt_r;
  logic                      pend_idx_r;
  lx_t                       s;
  logic                      acc;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_wstart(input logic [7:0] c);
    return is_alnum(c) || c == 8'h5f;
  endfunction

  function automatic lx_t f_push(input lx_t t, input logic [3:0] style, input logic m);
    if (t.n < 2'd2) begin
      t.recs[t.n[0]].is_write   = 1'b0;
      t.recs[t.n[0]].style      = style;
      t.recs[t.n[0]].need_match = m;
      t.recs[t.n[0]].len        = t.rc;
      t.recs[t.n[0]].final_run  = 1'b0;
      t.recs[t.n[0]].wlen       = t.wl;
      t.recs[t.n[0]].word       = t.wb;
      t.n = t.n + 2'd1;
    end
    return t;
  endfunction

  // Words starting with a digit or a dot are numbers; the rest go to the keyword search.
  // A word with no kept bytes, left by a start state of word, is plain default.
  function automatic lx_t f_emit(input lx_t t, input logic [3:0] style);
    logic dig;
    dig = (t.wl != '0) && ((t.wb[0] >= 8'h30 && t.wb[0] <= 8'h39) || t.wb[0] == 8'h2e);
    if (style == ST_WORD) begin
      if (t.wl == '0) begin
        t = f_push(t, ST_DEFAULT, 1'b0);
      end else begin
        t = f_push(t, dig ? ST_NUMBER : ST_WORD, !dig);
      end
    end else begin
      t = f_push(t, style, 1'b0);
    end
    return t;
  endfunction

  function automatic lx_t f_count(input lx_t t);
    if (t.rc != '1) t.rc = t.rc + 1'b1;
    return t;
  endfunction

  // Closes the run before the current byte.
  function automatic lx_t f_open(input lx_t t, input logic [3:0] style);
    logic first;
    first = t.ao && (t.rc == '0);
    if (t.rc != '0) t = f_emit(t, style);
    t.rc = {{(RUN_BITS-1){1'b0}}, 1'b1};
    t.ao = first;
    return t;
  endfunction

  // Closes the run including the current byte.
  function automatic lx_t f_close(input lx_t t, input logic [3:0] style);
    t = f_count(t);
    t = f_emit(t, style);
    t.rc = '0;
    t.ao = 1'b0;
    return t;
  endfunction

  function automatic lx_t f_begin_word(input lx_t t, input logic [7:0] b);
    t.wb[0] = b;
    t.wl = {{(WLEN_W-1){1'b0}}, 1'b1};
    t.ls = ST_WORD;
    return t;
  endfunction

  function automatic lx_t f_after(input lx_t t, input logic [7:0] b, input logic allow);
    if (b == 8'h2f) begin
      t.hk = HOLD_SLASH_AFTER;
      t.hv = 1'b1;
    end else if (b == 8'h22) t.ls = ST_STRING;
    else if (b == 8'h27) t.ls = ST_CHAR;
    else if (b == 8'h23) t.ls = ST_PRE;
    else if (allow && is_wstart(b)) t = f_begin_word(t, b);
    return t;
  endfunction

  function automatic lx_t f_resolve(input lx_t t, input logic [7:0] nx);
    t.hv = 1'b0;
    unique case (t.hk)
      HOLD_SLASH_OPEN: begin
        if (nx == 8'h2a) begin
          t = f_open(t, ST_DEFAULT);
          t.ls = ST_COMMENT;
        end else if (nx == 8'h2f) begin
          t = f_open(t, ST_DEFAULT);
          t.ls = ST_LINE;
        end else t = f_count(t);
      end
      HOLD_SLASH_AFTER: begin
        if (nx == 8'h2a) t.ls = ST_COMMENT;
        else if (nx == 8'h2f) t.ls = ST_LINE;
      end
      default: begin
        if (nx == 8'h22 || nx == 8'h27 || nx == 8'h5c) t.sk = 2'd1;
      end
    endcase
    return t;
  endfunction

  function automatic lx_t f_take(input lx_t t, input logic [7:0] b, input logic [3:0] init);
    logic [7:0] q;
    q = (t.ls == ST_STRING) ? 8'h22 : 8'h27;
    if (t.sk == 2'd1) begin
      t.sk = 2'd0;
      t = f_count(t);
    end else if (t.sk == 2'd2) begin
      t.sk = 2'd0;
      t = f_count(t);
      t.ao = 1'b0;
      t = f_after(t, b, 1'b1);
    end else if (t.ls == ST_DEFAULT) begin
      if (is_wstart(b)) begin
        t = f_open(t, ST_DEFAULT);
        t = f_begin_word(t, b);
      end else if (b == 8'h2f) begin
        t.hk = HOLD_SLASH_OPEN;
        t.hv = 1'b1;
      end else if (b == 8'h22 || b == 8'h27 || b == 8'h23) begin
        t = f_open(t, ST_DEFAULT);
        t.ls = (b == 8'h22) ? ST_STRING : ((b == 8'h27) ? ST_CHAR : ST_PRE);
      end else t = f_count(t);
    end else if (t.ls == ST_WORD) begin
      if (is_wstart(b) || b == 8'h2e) begin
        t = f_count(t);
        if (t.wl < WLEN_W'(WORD_KEEP)) begin
          t.wb[t.wl] = b;
          t.wl = t.wl + 1'b1;
        end
      end else begin
        t = f_open(t, ST_WORD);
        t.ls = ST_DEFAULT;
        t = f_after(t, b, 1'b0);
      end
    end else if (t.ls == ST_PRE) begin
      if ((b == 8'h0d || b == 8'h0a) && t.pb != 8'h5c) begin
        t = f_open(t, ST_PRE);
        t.ls = ST_DEFAULT;
      end else t = f_count(t);
    end else if (t.ls == ST_COMMENT) begin
      if (b == 8'h2f && t.pb == 8'h2a &&
          (t.rc >= RUN_BITS'(3) || (init == ST_COMMENT && t.ao))) begin
        t = f_close(t, ST_COMMENT);
        t.ls = ST_DEFAULT;
        t = f_after(t, b, 1'b0);
      end else t = f_count(t);
    end else if (t.ls == ST_LINE) begin
      if (b == 8'h0d || b == 8'h0a) begin
        t = f_open(t, ST_LINE);
        t.ls = ST_DEFAULT;
      end else t = f_count(t);
    end else if (t.ls == ST_STRING || t.ls == ST_CHAR) begin
      if (b == 8'h5c) begin
        t = f_count(t);
        t.hk = HOLD_ESCAPE;
        t.hv = 1'b1;
      end else if (b == q) begin
        t = f_close(t, t.ls);
        t.ls = ST_DEFAULT;
        t.sk = 2'd2;
      end else t = f_count(t);
    end else begin
      t = f_count(t);
    end
    t.pb = b;
    return t;
  endfunction

  assign acc           = in_word.valid && in_word.ready;
  assign in_word.ready = (pend_cnt_r == 2'd0) && !clearing;
  assign q_push        = (pend_cnt_r != 2'd0);
  assign q_din         = pend_r[pend_idx_r];

  always_comb begin
    s.ls   = lex_r;
    s.hv   = hv_r;
    s.hk   = hk_r;
    s.pb   = prev_r;
    s.sk   = skip_r;
    s.rc   = rc_r;
    s.ao   = ao_r;
    s.wl   = wl_r;
    s.wb   = wb_r;
    s.n    = 2'd0;
    s.recs = '0;
    if (in_word.mode) begin
      s.recs[0].is_write = 1'b1;
      s.recs[0].waddr    = KW_AW'({in_word.keyword_slot, in_word.keyword_pos});
      s.recs[0].wdata    = in_word.data_byte;
      s.n = 2'd1;
    end else begin
      if (s.hv) s = f_resolve(s, in_word.data_byte);
      s = f_take(s, in_word.data_byte, init_r);
      if (in_word.end_of_doc) begin
        if (s.hv) s = f_resolve(s, 8'h20);
        if (s.rc != '0) s = f_emit(s, s.ls);
        if (s.n != 2'd0) s.recs[s.n[1]].final_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r      <= ST_DEFAULT;
      init_r     <= ST_DEFAULT;
      hv_r       <= 1'b0;
      hk_r       <= HOLD_SLASH_OPEN;
      prev_r     <= 8'h20;
      skip_r     <= 2'd0;
      rc_r       <= '0;
      ao_r       <= 1'b1;
      wl_r       <= '0;
      dopen_r    <= 1'b0;
      pend_cnt_r <= 2'd0;
      pend_idx_r <= 1'b0;
    end else begin
      if (acc) begin
        pend_r     <= s.recs;
        pend_cnt_r <= s.n;
        pend_idx_r <= 1'b0;
        if (!in_word.mode) begin
          wb_r <= s.wb;
          if (in_word.end_of_doc) begin
            // Document done: back to document start.
            lex_r   <= init_r;
            hv_r    <= 1'b0;
            hk_r    <= HOLD_SLASH_OPEN;
            prev_r  <= 8'h20;
            skip_r  <= 2'd0;
            rc_r    <= '0;
            ao_r    <= 1'b1;
            wl_r    <= '0;
            dopen_r <= 1'b0;
          end else begin
            lex_r   <= s.ls;
            hv_r    <= s.hv;
            hk_r    <= s.hk;
            prev_r  <= s.pb;
            skip_r  <= s.sk;
            rc_r    <= s.rc;
            ao_r    <= s.ao;
            wl_r    <= s.wl;
            dopen_r <= 1'b1;
          end
        end
      end else if (q_push && !q_full) begin
        pend_cnt_r <= pend_cnt_r - 2'd1;
        pend_idx_r <= 1'b1;
      end
      if (cfg_we) begin
        init_r <= cfg_data;
        if (!dopen_r && !acc) lex_r <= cfg_data;
      end
    end
  end

endmodule

// File: sv/cslx_queue.sv
module cslx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cslx_pkg::rec_t din,
  output logic           full,
  input  logic           pop,
  output cslx_pkg::rec_t dout,
  output logic           empty
);
  import cslx_pkg::*;

  rec_t            mem_r [QDEPTH];
  logic [Q_AW-1:0] wp_r, rp_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

endmodule

// File: sv/cslx_back.sv
module cslx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cslx_pkg::rec_t q_dout,
  input  logic           q_empty,
  output logic           q_pop,
  cslx_out_if.source     out_word,
  output logic           clearing
);
  import cslx_pkg::*;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_RD    = 5'b00100,
    B_CMP   = 5'b01000,
    B_EMIT  = 5'b10000
  } bstate_t;

  logic [7:0]          kw_mem [KW_ENTRIES*KW_BYTES];
  logic [7:0]          rd_r;
  bstate_t             st_r, st_nxt;
  logic [KW_AW-1:0]    clr_r, clr_nxt;
  logic [E_W-1:0]      e_r, e_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  rec_t                cur_r, cur_nxt;
  logic                ov_r, ov_nxt;
  logic [3:0]          ostyle_r, ostyle_nxt;
  logic [RUN_BITS-1:0] olen_r, olen_nxt;
  logic                ofin_r, ofin_nxt;
  logic                mem_we;
  logic [KW_AW-1:0]    mem_wa;
  logic [7:0]          mem_wd;
  logic [7:0]          expect_b;
  logic                slot_free;

  assign clearing           = (st_r == B_CLEAR);
  assign out_word.valid      = ov_r;
  assign out_word.style      = ostyle_r;
  assign out_word.run_length = olen_r;
  assign out_word.final_run  = ofin_r;
  assign slot_free           = !ov_r || out_word.ready;

  // Byte expected at position k of a matching entry: the word, then a terminator.
  always_comb begin
    if (WLEN_W'(k_r) < cur_r.wlen && k_r < K_W'(WORD_KEEP)) begin
      expect_b = cur_r.word[k_r];
    end else begin
      expect_b = 8'h00;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    e_nxt      = e_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    ov_nxt     = ov_r && !out_word.ready;
    ostyle_nxt = ostyle_r;
    olen_nxt   = olen_r;
    ofin_nxt   = ofin_r;
    mem_we     = 1'b0;
    mem_wa     = clr_r;
    mem_wd     = 8'h00;
    q_pop      = 1'b0;
    unique case (st_r)
      B_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) st_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_dout.is_write) begin
            mem_we = 1'b1;
            mem_wa = q_dout.waddr;
            mem_wd = q_dout.wdata;
          end else begin
            cur_nxt = q_dout;
            e_nxt   = '0;
            k_nxt   = '0;
            st_nxt  = q_dout.need_match ? B_RD : B_EMIT;
          end
        end
      end
      B_RD: st_nxt = B_CMP;
      B_CMP: begin
        if (rd_r == expect_b) begin
          if (WLEN_W'(k_r) == cur_r.wlen) begin
            cur_nxt.style = ST_WORD;
            st_nxt = B_EMIT;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = B_RD;
          end
        end else if (e_r == E_W'(KW_ENTRIES - 1)) begin
          cur_nxt.style = ST_DEFAULT;
          st_nxt = B_EMIT;
        end else begin
          e_nxt  = e_r + 1'b1;
          k_nxt  = '0;
          st_nxt = B_RD;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          ostyle_nxt = cur_r.style;
          olen_nxt   = cur_r.len;
          ofin_nxt   = cur_r.final_run;
          st_nxt     = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) kw_mem[mem_wa] <= mem_wd;
    rd_r <= kw_mem[{e_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    k_r      <= k_nxt;
    cur_r    <= cur_nxt;
    ostyle_r <= ostyle_nxt;
    olen_r   <= olen_nxt;
    ofin_r   <= ofin_nxt;
  end

endmodule

// File: sv/c_source_syntax_lexer_unit.sv
// C source lexer for syntax coloring. Words arrive on in_word: mode 0 carries one
// document byte (end_of_doc marks the last one), mode 1 writes one byte of the
// keyword store at keyword_slot/keyword_pos. Styled runs leave on out_word as
// style, run_length and final_run. cfg_we/cfg_data load the start state of the
// next document; write it only while the block is idle.
// The lexer front takes one word whenever its two-entry staging buffer is empty,
// so it stalls while the runs that a byte closes are pushed to the queue. Runs
// pass through a four-entry queue to the back end. A word that may be a keyword
// is matched by walking the keyword memory one byte at a time through its single
// read port, each byte first read and then compared. The queue lets the front
// keep lexing while a search runs.
// After reset the back end zeroes the 2048-byte keyword memory, one byte a cycle;
// in_word.ready stays low until that clear is done. When the receiver stalls, the
// output register holds, the queue fills and in_word.ready drops.
module c_source_syntax_lexer_unit (
  input  logic       clk,
  input  logic       rst_n,
  cslx_in_if.sink    in_word,
  cslx_out_if.source out_word,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);
  import cslx_pkg::*;

  rec_t q_din, q_dout;
  logic q_push, q_full, q_pop, q_empty;
  logic clearing;

  // Front: byte-level lexer state machine, one lookahead byte.
  cslx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .clearing (clearing),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_din    (q_din),
    .q_push   (q_push),
    .q_full   (q_full)
  );

  // Queue of closed runs and keyword writes, kept in order.
  cslx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back: keyword memory, keyword search and the output register.
  cslx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_dout   (q_dout),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_word (out_word),
    .clearing (clearing)
  );

endmodule

// File: sv/cslx_checker.sv
module cslx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_run_length
);

  // Valid output holds while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != 24'd0)
    else $error("empty run emitted");

  // The keyword memory clear keeps input blocked right after reset.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_reset_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind c_source_syntax_lexer_unit cslx_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_word.ready),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .out_run_length (out_word.run_length)
);

// File: tb/cslx_run_checker.sv
module cslx_run_checker (
  input  logic       clk,
  input  logic       rst_n,
  cslx_in_if         in_word,
  cslx_out_if        out_word,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         runs_pending,
  output int         runs_checked
);
  import cslx_pkg::*;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  typedef enum logic [1:0] {HOLD_SLASH_OPEN, HOLD_SLASH_AFTER, HOLD_ESCAPE} hold_e;

  typedef struct {
    logic [3:0]          style;
    logic [RUN_BITS-1:0] len;
    logic                fin;
  } run_t;

  run_t run_q[$];
  run_t item_runs[$];

  logic [7:0]          kw_mem [KW_ENTRIES][KW_BYTES];
  logic [7:0]          word_buf [WORD_KEEP];
  int                  word_len;
  logic [3:0]          start_style;
  logic [3:0]          lex;
  logic                held_valid;
  hold_e               held_kind;
  logic [7:0]          prev_byte;
  logic [1:0]          skip;
  logic [RUN_BITS-1:0] run_cnt;
  logic                at_origin;
  logic                doc_open;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic keyword_hit();
    logic same;
    if (word_len == 0) return 1'b0;
    for (int e = 0; e < KW_ENTRIES; e++) begin
      if (kw_mem[e][0] == 8'h00) continue;
      same = 1'b1;
      for (int k = 0; k < word_len; k++)
        if (kw_mem[e][k] != word_buf[k]) same = 1'b0;
      if (same && word_len < KW_BYTES && kw_mem[e][word_len] != 8'h00) same = 1'b0;
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [3:0] word_style();
    if (word_len > 0 && ((word_buf[0] >= "0" && word_buf[0] <= "9") || word_buf[0] == CH_DOT))
      return ST_NUMBER;
    return keyword_hit() ? ST_WORD : ST_DEFAULT;
  endfunction

  task automatic emit_run(logic [3:0] s, logic [RUN_BITS-1:0] n);
    run_t r;
    if (n == 0 || item_runs.size() >= 2) return;
    r.style = s;
    r.len = n;
    r.fin = 1'b0;
    item_runs.push_back(r);
  endtask

  task automatic bump();
    if (run_cnt < RUN_MAX) run_cnt++;
  endtask

  task automatic open_run(logic [3:0] s);
    logic first;
    first = at_origin && run_cnt == 0;
    emit_run(s, run_cnt);
    run_cnt = 1;
    at_origin = first;
  endtask

  task automatic close_run(logic [3:0] s);
    bump();
    emit_run(s, run_cnt);
    run_cnt = 0;
    at_origin = 1'b0;
  endtask

  task automatic begin_word(logic [7:0] b);
    word_buf[0] = b;
    word_len = 1;
    lex = ST_WORD;
  endtask

  task automatic hold(hold_e k);
    held_kind = k;
    held_valid = 1'b1;
  endtask

  task automatic after_close(logic [7:0] b, logic allow_word);
    if (b == CH_SLASH) hold(HOLD_SLASH_AFTER);
    else if (b == CH_DQ) lex = ST_STRING;
    else if (b == CH_SQ) lex = ST_CHAR;
    else if (b == CH_HASH) lex = ST_PRE;
    else if (allow_word && (is_alnum(b) || b == CH_US)) begin_word(b);
  endtask

  task automatic resolve_held(logic [7:0] nx);
    held_valid = 1'b0;
    case (held_kind)
      HOLD_SLASH_OPEN: begin
        if (nx == CH_STAR) begin open_run(ST_DEFAULT); lex = ST_COMMENT; end
        else if (nx == CH_SLASH) begin open_run(ST_DEFAULT); lex = ST_LINE; end
        else bump();
      end
      HOLD_SLASH_AFTER: begin
        if (nx == CH_STAR) lex = ST_COMMENT;
        else if (nx == CH_SLASH) lex = ST_LINE;
      end
      default: begin
        if (nx == CH_DQ || nx == CH_SQ || nx == CH_BSL) skip = 2'd1;
      end
    endcase
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [7:0] q;
    if (skip == 2'd1) begin
      skip = 0;
      bump();
    end else if (skip == 2'd2) begin
      skip = 0;
      bump();
      at_origin = 1'b0;
      after_close(b, 1'b1);
    end else if (lex == ST_DEFAULT) begin
      if (is_alnum(b) || b == CH_US) begin open_run(ST_DEFAULT); begin_word(b); end
      else if (b == CH_SLASH) hold(HOLD_SLASH_OPEN);
      else if (b == CH_DQ) begin open_run(ST_DEFAULT); lex = ST_STRING; end
      else if (b == CH_SQ) begin open_run(ST_DEFAULT); lex = ST_CHAR; end
      else if (b == CH_HASH) begin open_run(ST_DEFAULT); lex = ST_PRE; end
      else bump();
    end else if (lex == ST_WORD) begin
      if (is_alnum(b) || b == CH_US || b == CH_DOT) begin
        bump();
        if (word_len < WORD_KEEP) begin
          word_buf[word_len] = b;
          word_len++;
        end
      end else begin
        open_run(word_style());
        lex = ST_DEFAULT;
        after_close(b, 1'b0);
      end
    end else if (lex == ST_PRE) begin
      if ((b == CH_CR || b == CH_LF) && prev_byte != CH_BSL) begin
        open_run(ST_PRE);
        lex = ST_DEFAULT;
      end else bump();
    end else if (lex == ST_COMMENT) begin
      if (b == CH_SLASH && prev_byte == CH_STAR &&
          (run_cnt >= 3 || (start_style == ST_COMMENT && at_origin))) begin
        close_run(ST_COMMENT);
        lex = ST_DEFAULT;
        after_close(b, 1'b0);
      end else bump();
    end else if (lex == ST_LINE) begin
      if (b == CH_CR || b == CH_LF) begin open_run(ST_LINE); lex = ST_DEFAULT; end
      else bump();
    end else if (lex == ST_STRING || lex == ST_CHAR) begin
      q = (lex == ST_STRING) ? CH_DQ : CH_SQ;
      if (b == CH_BSL) begin bump(); hold(HOLD_ESCAPE); end
      else if (b == q) begin close_run(lex); lex = ST_DEFAULT; skip = 2'd2; end
      else bump();
    end else begin
      bump();
    end
    prev_byte = b;
  endtask

  task automatic doc_restart();
    lex = start_style;
    held_valid = 1'b0;
    held_kind = HOLD_SLASH_OPEN;
    prev_byte = CH_SP;
    skip = 0;
    run_cnt = 0;
    at_origin = 1'b1;
    word_len = 0;
    doc_open = 1'b0;
  endtask

  task automatic lex_word();
    logic [7:0] b;
    b = in_word.data_byte;
    item_runs.delete();
    if (in_word.mode) begin
      kw_mem[in_word.keyword_slot][in_word.keyword_pos] = b;
      return;
    end
    doc_open = 1'b1;
    if (held_valid) resolve_held(b);
    take_byte(b);
    if (in_word.end_of_doc) begin
      if (held_valid) resolve_held(CH_SP);
      if (run_cnt > 0) emit_run(lex == ST_WORD ? word_style() : lex, run_cnt);
      if (item_runs.size() > 0) item_runs[item_runs.size()-1].fin = 1'b1;
      doc_restart();
    end
    foreach (item_runs[i]) run_q.push_back(item_runs[i]);
  endtask

  always @(posedge clk) begin
    run_t e;
    if (!rst_n) begin
      start_style = ST_DEFAULT;
      foreach (kw_mem[i, j]) kw_mem[i][j] = 8'h00;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
      doc_restart();
      run_q.delete();
      fail_count = 0;
      runs_checked = 0;
    end else begin
      if (cfg_we) begin
        start_style = cfg_data;
        if (!doc_open) lex = cfg_data;
      end
      if (in_word.valid && in_word.ready) lex_word();
      if (out_word.valid && out_word.ready) begin
        runs_checked++;
        if (run_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("checker: unexpected run style=%0d len=%0d final=%0b",
                     out_word.style, out_word.run_length, out_word.final_run);
        end else begin
          e = run_q.pop_front();
          if (e.style != out_word.style || e.len != out_word.run_length ||
              e.fin != out_word.final_run) begin
            fail_count++;
            if (fail_count <= 10)
              $display("checker: run mismatch exp style=%0d len=%0d final=%0b, got %0d %0d %0b",
                       e.style, e.len, e.fin, out_word.style, out_word.run_length,
                       out_word.final_run);
          end
        end
      end
    end
    runs_pending = run_q.size();
  end
endmodule

// File: tb/tb_top.sv
module tb_top;
  import cslx_pkg::*;

  // Cycles with no word moving on either channel before the run is declared hung.
  // A long keyword search and the keyword memory clear after reset both stay well
  // inside this limit, so it leaves a wide margin.
  localparam int HANG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [3:0] cfg_data;

  cslx_in_if  in_w();
  cslx_out_if out_w();

  int fail_count;
  int runs_pending;
  int runs_checked;
  int words_sent;
  int docs_sent;
  int send_idle;
  int recv_idle;
  int quiet_cycles;
  bit stall_request;

  c_source_syntax_lexer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_w),
    .out_word (out_w),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  cslx_run_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_word      (in_w),
    .out_word     (out_w),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .runs_pending (runs_pending),
    .runs_checked (runs_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // The watchdog counts cycles in which no word is accepted on either side.
  always @(posedge clk) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb_top: no progress for %0d cycles", HANG_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // The receiver drops ready at random, and on request it holds off for a long
  // stretch so that the run queue fills and the block stops taking input.
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_w.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_w.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sends one word and returns once it has been accepted. Valid stays high
  // between back-to-back words; it only drops for idle cycles.
  task automatic send_word(logic mode, logic [7:0] b, logic [5:0] slot, logic [4:0] pos,
                           logic eod);
    while ($urandom_range(99) < send_idle) begin
      in_w.valid <= 1'b0;
      @(posedge clk);
    end
    in_w.valid        <= 1'b1;
    in_w.mode         <= mode;
    in_w.data_byte    <= b;
    in_w.keyword_slot <= slot;
    in_w.keyword_pos  <= pos;
    in_w.end_of_doc   <= eod;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    words_sent++;
  endtask

  // Loads a keyword with its terminating zero. The end-of-document flag is set
  // at random since mode-1 words must ignore it.
  task automatic load_keyword(int slot, string s);
    for (int i = 0; i <= s.len(); i++)
      send_word(1'b1, (i < s.len()) ? s[i] : 8'h00, slot[5:0], i[4:0],
                1'($urandom_range(1)));
  endtask

  // Sends a whole document; the last byte carries the end-of-document flag.
  task automatic send_doc(string s);
    for (int i = 0; i < s.len(); i++)
      send_word(1'b0, s[i], 6'($urandom), 5'($urandom), i == s.len() - 1);
    docs_sent++;
  endtask

  // The start style may only change once every run is out. Keyword writes can
  // still sit in the queue after the last run is out, so a short pause follows.
  task automatic set_start_style(logic [3:0] v);
    in_w.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // One random piece of C text. Most pieces are well formed so that every lexer
  // state is entered; the last case is raw noise over every byte value but zero.
  function automatic string fragment();
    string s;
    int n;
    byte unsigned c;
    s = "";
    case ($urandom_range(13))
      0, 1: begin
        case ($urandom_range(5))
          0: s = "if";
          1: s = "int";
          2: s = "for";
          3: s = "do";
          4: s = "in";
          default: s = "x_1";
        endcase
      end
      2: s = $sformatf("%0d", $urandom_range(9999));
      3: s = ".5e1";
      4: s = " ";
      5: s = "/* c */";
      6: s = "/**/";
      7: s = "// line\n";
      8: s = "\"s\\\"q\\\\\"";
      9: s = "'\\''";
      10: s = "#inc \\\n x\r";
      11: s = "a/b*c";
      12: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          c = $urandom_range(32, 126);
          s = {s, string'(c)};
        end
      end
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          c = $urandom_range(255);
          if (c == 0) c = 8'h01;
          s = {s, string'(c)};
        end
      end
    endcase
    return s;
  endfunction

  function automatic string random_doc();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) s = {s, fragment()};
    return s;
  endfunction

  initial begin
    logic [3:0] styles [6];
    int target;

    styles = '{ST_DEFAULT, ST_COMMENT, 4'd15, ST_PRE, 4'd3, ST_STRING};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 4'd0;
    in_w.valid = 1'b0;
    in_w.mode = 1'b0;
    in_w.data_byte = 8'h00;
    in_w.keyword_slot = 6'd0;
    in_w.keyword_pos = 5'd0;
    in_w.end_of_doc = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    words_sent = 0;
    docs_sent = 0;
    stall_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: keywords in the first and last slots, a word past the
    // kept length, both comment kinds, escapes, a closing quote as last byte,
    // and a block comment continued from a previous document.
    load_keyword(0, "int");
    load_keyword(63, "if");
    send_doc("int x=1.5;/*c*/ //l\n#d \\\nq\r\"a\\\"b\" 'c'/");
    send_doc("abcdefghijklmnopqrstuvwxyz0123456789 ifx \"z\"");
    set_start_style(ST_COMMENT);
    send_doc("*/if");
    set_start_style(4'd15);
    send_doc("\xff\x01");

    // Random part in three idling phases, each with two start styles.
    target = 950;
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 9 : (p == 1) ? 85 : 0;
      recv_idle = (p == 0) ? 85 : (p == 1) ? 9 : 0;
      for (int c = 0; c < 2; c++) begin
        set_start_style(styles[p * 2 + c]);
        if (p == 2 && c == 0) stall_request = 1'b1;
        while (words_sent < target * (p * 2 + c + 1) / 6) begin
          if ($urandom_range(9) == 0)
            send_word(1'b1, 8'($urandom), 6'($urandom), 5'($urandom),
                      1'($urandom_range(1)));
          else if ($urandom_range(9) == 0)
            load_keyword($urandom_range(63), fragment());
          else
            send_doc(random_doc());
        end
      end
    end
    in_w.valid <= 1'b0;

    while (runs_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("tb_top: %0d words sent in %0d documents, %0d runs checked",
             words_sent, docs_sent, runs_checked);
    $display("tb_top: start styles 0, 1, 3, 6, 9, 15 and a long receiver stall covered");
    if (fail_count == 0 && runs_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/cslx_pkg.sv
sv/cslx_in_if.sv
sv/cslx_out_if.sv
sv/cslx_front.sv
sv/cslx_queue.sv
sv/cslx_back.sv
sv/c_source_syntax_lexer_unit.sv
sv/cslx_checker.sv
tb/cslx_run_checker.sv
tb/tb_top.sv
